FILE: rtl/sgvp_pkg.sv
package sgvp_pkg;

   // Grid geometry
   localparam int INTERIOR_CELLS = 12;
   localparam int PADDED         = INTERIOR_CELLS + 2;
   localparam int POS_W          = $clog2(PADDED);
   localparam int LINE_DEPTH     = 2 * PADDED;
   localparam int ADDR_W         = $clog2(LINE_DEPTH);
   localparam int COORD_W        = 4;

   // Number formats
   localparam int VELOCITY_WIDTH = 32;
   localparam int VW             = VELOCITY_WIDTH;
   localparam int FRAC_BITS      = VW - 4;
   localparam int GAIN_W         = 40;
   localparam int GAIN_LO_W      = GAIN_W / 2;
   localparam int GAIN_HI_W      = GAIN_W - GAIN_LO_W;

   // Datapath widths
   localparam int LAP_W  = VW + 2;
   localparam int DIF_W  = VW + 1;
   localparam int SUM_W  = VW + 2;
   localparam int PA_W   = VW + DIF_W;
   localparam int PB_W   = SUM_W + DIF_W;
   localparam int ADV_W  = VW + 5;
   localparam int OP_W   = ADV_W;
   localparam int PART_W = OP_W + GAIN_HI_W + 1;
   localparam int TERM_W = OP_W + 1;
   localparam int RES_W  = TERM_W + 3;
   localparam int RND_W  = OP_W + GAIN_W + 2;

   // Stream widths
   localparam int REQ_DATA_W = ((2 * VW + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_W + 2 * VW + 7) / 8) * 8;
   localparam int RSP_USER_W = 3;

   // Configuration
   localparam int CSR_INDEX_W = 2;
   localparam logic [GAIN_W-1:0] DIFF_GAIN_RESET = GAIN_W'(15833);
   localparam logic [GAIN_W-1:0] ADV_GAIN_RESET  = GAIN_W'(659706976);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIFF_X,
      CSR_DIFF_Y,
      CSR_ADV_X,
      CSR_ADV_Y
   } sgvp_csr_type;

   typedef struct packed {
      logic signed [VW-1:0] u;
      logic signed [VW-1:0] v;
   } sgvp_pair_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               u_def;
      logic               v_def;
      logic               last;
   } sgvp_meta_type;

   // Load enables of the arithmetic stages
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic s7;
      logic s8;
   } sgvp_stage_en_type;

   // Shift right by sh, rounding to nearest with ties away from zero.
   function automatic logic signed [RND_W-1:0] round_shift(input logic signed [RND_W-1:0] p,
                                                          input int unsigned sh);
      logic signed [RND_W-1:0] half;
      half = {{(RND_W-1){1'b0}}, 1'b1} << (sh - 1);
      if (p[RND_W-1]) begin
         half = half - {{(RND_W-1){1'b0}}, 1'b1};
      end
      return (p + half) >>> sh;
   endfunction

endpackage

FILE: rtl/staggered_grid_velocity_predictor.sv
// A result leaves on rsp after stage 1 (line store reads), stage 2 (window), the arithmetic stages and stage 9.
// Throughput: one cell per cycle while rsp_tready holds, set by the line store port and the window shift;
// every stage of the arithmetic chain takes a new item each cycle unless the stage after it is stalled.
// Reset clears the position counters, the window cells and the pipeline, and loads the gains.
// The line store is not cleared; a grid writes its rows before reading them.
module staggered_grid_velocity_predictor import sgvp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Cells in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // u_value, v_value
   input  logic                   req_tuser,   // grid_start
   // Predictions out
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // cell_col, cell_row, u_predicted, v_predicted
   output logic [RSP_USER_W-1:0]  rsp_tuser,   // u_defined, v_defined, saturated
   output logic                   rsp_tlast,   // grid_last
   // Gains
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]      csr_wdata
);

   logic [GAIN_W-1:0] gain_dx_ff, gain_dy_ff, gain_ax_ff, gain_ay_ff;
   logic [POS_W-1:0]  col_ff, row_ff, col_in, row_in, col_eff, row_eff;
   logic [9:1]        valid_ff, valid_in, free;
   logic              accept;
   logic              window_shift;

   logic [ADDR_W-1:0] addr_same, addr_other;
   sgvp_pair_type     in_pair, rd_same, rd_other, in1_ff;
   sgvp_meta_type     meta_new, meta1_ff, meta2_ff;
   sgvp_meta_type     meta_ff [3:8];
   logic              emit_new, emit1_ff, emit2_ff;

   sgvp_pair_type     cur [3];
   sgvp_pair_type     win [3][3];
   sgvp_stage_en_type stage_en;

   logic signed [VW-1:0] u_pred, v_pred, u_centre, v_centre;
   logic                 u_sat, v_sat;
   logic signed [VW-1:0] u_out_ff, v_out_ff;
   sgvp_meta_type        meta_out_ff;
   logic                 sat_out_ff;

   // Gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_dx_ff <= DIFF_GAIN_RESET;
         gain_dy_ff <= DIFF_GAIN_RESET;
         gain_ax_ff <= ADV_GAIN_RESET;
         gain_ay_ff <= ADV_GAIN_RESET;
      end else if (csr_wen) begin
         unique case (sgvp_csr_type'(csr_index))
            CSR_DIFF_X: gain_dx_ff <= csr_wdata;
            CSR_DIFF_Y: gain_dy_ff <= csr_wdata;
            CSR_ADV_X:  gain_ax_ff <= csr_wdata;
            CSR_ADV_Y:  gain_ay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Flow control: a stage loads when it is empty or its item moves on.
   always_comb begin
      free[9] = !valid_ff[9] || rsp_tready;
      for (int k = 8; k >= 1; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end
      valid_in[1] = free[1] ? req_tvalid : valid_ff[1];
      valid_in[2] = free[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = free[3] ? (valid_ff[2] && emit2_ff) : valid_ff[3];
      for (int k = 4; k <= 9; k++) begin
         valid_in[k] = free[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = free[1];
   assign accept     = req_tvalid && free[1];

   // Padded position of the incoming item and the next one.
   always_comb begin
      col_eff = req_tuser ? '0 : col_ff;
      row_eff = req_tuser ? '0 : row_ff;
      col_in  = col_eff + POS_W'(1);
      row_in  = row_eff;
      if (col_eff == POS_W'(PADDED - 1)) begin
         col_in = '0;
         row_in = (row_eff == POS_W'(PADDED - 1)) ? '0 : row_eff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // The store keeps one row per parity; the same parity holds the row two back.
   assign addr_same  = ADDR_W'(row_eff[0] ? PADDED : 0) + ADDR_W'(col_eff);
   assign addr_other = ADDR_W'(row_eff[0] ? 0 : PADDED) + ADDR_W'(col_eff);
   assign in_pair.u  = req_tdata[VW-1:0];
   assign in_pair.v  = req_tdata[2*VW-1:VW];

   always_comb begin
      meta_new.col   = COORD_W'(col_eff - POS_W'(1));
      meta_new.row   = COORD_W'(row_eff - POS_W'(1));
      meta_new.u_def = col_eff >= POS_W'(3);
      meta_new.v_def = row_eff >= POS_W'(3);
      meta_new.last  = (col_eff == POS_W'(PADDED - 1)) && (row_eff == POS_W'(PADDED - 1));
      emit_new       = (col_eff >= POS_W'(2)) && (row_eff >= POS_W'(2));
   end

   sgvp_line_store u_line_store (
      .clock      (clock),
      .wr_en      (accept),
      .addr_same  (addr_same),
      .addr_other (addr_other),
      .wr_data    (in_pair),
      .rd_same    (rd_same),
      .rd_other   (rd_other)
   );

   // Stage 1: item beside its two line store reads.
   always_ff @(posedge clock) begin
      if (accept) begin
         in1_ff   <= in_pair;
         meta1_ff <= meta_new;
         emit1_ff <= emit_new;
      end
   end

   assign cur[0] = rd_same;
   assign cur[1] = rd_other;
   assign cur[2] = in1_ff;

   // The window moves on whenever the item in stage 1 passes into stage 2.
   assign window_shift = free[2] && valid_ff[1];

   // Stage 2: the 3x3 window, a row of cells shifting west by one column per item.
   for (genvar y = 0; y < 3; y++) begin : g_row
      sgvp_cell u_cell_e (
         .clock (clock), .reset (reset), .shift_en (window_shift),
         .pair_in (cur[y]), .pair_out (win[2][y])
      );
      sgvp_cell u_cell_c (
         .clock (clock), .reset (reset), .shift_en (window_shift),
         .pair_in (win[2][y]), .pair_out (win[1][y])
      );
      sgvp_cell u_cell_w (
         .clock (clock), .reset (reset), .shift_en (window_shift),
         .pair_in (win[1][y]), .pair_out (win[0][y])
      );
   end

   always_ff @(posedge clock) begin
      if (window_shift) begin
         meta2_ff <= meta1_ff;
         emit2_ff <= emit1_ff;
      end
   end

   // Arithmetic stages and the position data that travels beside them.
   always_comb begin
      stage_en.s3 = free[3] && valid_ff[2];
      stage_en.s4 = free[4] && valid_ff[3];
      stage_en.s5 = free[5] && valid_ff[4];
      stage_en.s6 = free[6] && valid_ff[5];
      stage_en.s7 = free[7] && valid_ff[6];
      stage_en.s8 = free[8] && valid_ff[7];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) meta_ff[3] <= meta2_ff;
      if (stage_en.s4) meta_ff[4] <= meta_ff[3];
      if (stage_en.s5) meta_ff[5] <= meta_ff[4];
      if (stage_en.s6) meta_ff[6] <= meta_ff[5];
      if (stage_en.s7) meta_ff[7] <= meta_ff[6];
      if (stage_en.s8) meta_ff[8] <= meta_ff[7];
   end

   sgvp_predict u_predict_u (
      .clock      (clock),
      .stage_en   (stage_en),
      .centre     (win[1][1].u),
      .west       (win[0][1].u),
      .east       (win[2][1].u),
      .south      (win[1][0].u),
      .north      (win[1][2].u),
      .self_hi    (win[2][1].u),
      .self_lo    (win[0][1].u),
      .cross_a    (win[0][1].v),
      .cross_b    (win[0][2].v),
      .cross_c    (win[1][1].v),
      .cross_d    (win[1][2].v),
      .cross_hi   (win[1][2].u),
      .cross_lo   (win[1][0].u),
      .gain_lap_x (gain_dx_ff),
      .gain_lap_y (gain_dy_ff),
      .gain_self  (gain_ax_ff),
      .gain_cross (gain_ay_ff),
      .pred       (u_pred),
      .centre_out (u_centre),
      .sat        (u_sat)
   );

   sgvp_predict u_predict_v (
      .clock      (clock),
      .stage_en   (stage_en),
      .centre     (win[1][1].v),
      .west       (win[0][1].v),
      .east       (win[2][1].v),
      .south      (win[1][0].v),
      .north      (win[1][2].v),
      .self_hi    (win[1][2].v),
      .self_lo    (win[1][0].v),
      .cross_a    (win[1][0].u),
      .cross_b    (win[1][1].u),
      .cross_c    (win[2][0].u),
      .cross_d    (win[2][1].u),
      .cross_hi   (win[2][1].v),
      .cross_lo   (win[0][1].v),
      .gain_lap_x (gain_dx_ff),
      .gain_lap_y (gain_dy_ff),
      .gain_self  (gain_ay_ff),
      .gain_cross (gain_ax_ff),
      .pred       (v_pred),
      .centre_out (v_centre),
      .sat        (v_sat)
   );

   // Stage 9: output register; a component outside its update range keeps its centre.
   always_ff @(posedge clock) begin
      if (free[9] && valid_ff[8]) begin
         meta_out_ff <= meta_ff[8];
         u_out_ff    <= meta_ff[8].u_def ? u_pred : u_centre;
         v_out_ff    <= meta_ff[8].v_def ? v_pred : v_centre;
         sat_out_ff  <= (meta_ff[8].u_def && u_sat) || (meta_ff[8].v_def && v_sat);
      end
   end

   assign rsp_tvalid = valid_ff[9];
   assign rsp_tdata  = RSP_DATA_W'({v_out_ff, u_out_ff, meta_out_ff.row, meta_out_ff.col});
   assign rsp_tuser  = {sat_out_ff, meta_out_ff.v_def, meta_out_ff.u_def};
   assign rsp_tlast  = meta_out_ff.last;

endmodule

FILE: rtl/sgvp_cell.sv
module sgvp_cell import sgvp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_en,
   input  sgvp_pair_type pair_in,
   output sgvp_pair_type pair_out
);

   sgvp_pair_type pair_ff;

   // One window position: takes its neighbour's pair when the window shifts.
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
      end else if (shift_en) begin
         pair_ff <= pair_in;
      end
   end

   assign pair_out = pair_ff;

endmodule

FILE: rtl/sgvp_line_store.sv
module sgvp_line_store import sgvp_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr_same,
   input  logic [ADDR_W-1:0] addr_other,
   input  sgvp_pair_type     wr_data,
   output sgvp_pair_type     rd_same,
   output sgvp_pair_type     rd_other
);

   sgvp_pair_type mem [LINE_DEPTH];
   sgvp_pair_type rd_same_ff;
   sgvp_pair_type rd_other_ff;

   // Both rows are read before the new item overwrites the older one.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_same_ff      <= mem[addr_same];
         rd_other_ff     <= mem[addr_other];
         mem[addr_same]  <= wr_data;
      end
   end

   assign rd_same  = rd_same_ff;
   assign rd_other = rd_other_ff;

endmodule

FILE: rtl/sgvp_predict.sv
module sgvp_predict import sgvp_pkg::*; (
   input  logic                 clock,
   input  sgvp_stage_en_type    stage_en,
   input  logic signed [VW-1:0] centre,
   input  logic signed [VW-1:0] west,
   input  logic signed [VW-1:0] east,
   input  logic signed [VW-1:0] south,
   input  logic signed [VW-1:0] north,
   input  logic signed [VW-1:0] self_hi,
   input  logic signed [VW-1:0] self_lo,
   input  logic signed [VW-1:0] cross_a,
   input  logic signed [VW-1:0] cross_b,
   input  logic signed [VW-1:0] cross_c,
   input  logic signed [VW-1:0] cross_d,
   input  logic signed [VW-1:0] cross_hi,
   input  logic signed [VW-1:0] cross_lo,
   input  logic [GAIN_W-1:0]    gain_lap_x,
   input  logic [GAIN_W-1:0]    gain_lap_y,
   input  logic [GAIN_W-1:0]    gain_self,
   input  logic [GAIN_W-1:0]    gain_cross,
   output logic signed [VW-1:0] pred,
   output logic signed [VW-1:0] centre_out,
   output logic                 sat
);

   localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((64'sd1 <<< (VW - 1)) - 64'sd1);
   localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);

   logic signed [VW-1:0]     c3_ff, c4_ff, c5_ff, c6_ff, c7_ff;
   logic signed [LAP_W-1:0]  lx3_ff, ly3_ff, lx4_ff, ly4_ff, lx5_ff, ly5_ff;
   logic signed [DIF_W-1:0]  sd3_ff, cd3_ff;
   logic signed [SUM_W-1:0]  cs3_ff;
   logic signed [PA_W-1:0]   pa4_ff;
   logic signed [PB_W-1:0]   pb4_ff;
   logic signed [ADV_W-1:0]  a5_ff, b5_ff;
   logic signed [PART_W-1:0] plo6_ff [4];
   logic signed [PART_W-1:0] phi6_ff [4];
   logic signed [TERM_W-1:0] t7_ff [4];
   logic signed [VW-1:0]     pred_ff, centre8_ff;
   logic                     sat_ff;

   logic signed [OP_W-1:0]        op5 [4];
   logic [GAIN_W-1:0]             gain [4];
   logic signed [RES_W-1:0]       sum7;

   // Stage 3: Laplacian parts, differences and the four-point cross sum.
   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         c3_ff  <= centre;
         lx3_ff <= LAP_W'(west) + LAP_W'(east) - (LAP_W'(centre) <<< 1);
         ly3_ff <= LAP_W'(south) + LAP_W'(north) - (LAP_W'(centre) <<< 1);
         sd3_ff <= DIF_W'(self_hi) - DIF_W'(self_lo);
         cd3_ff <= DIF_W'(cross_hi) - DIF_W'(cross_lo);
         cs3_ff <= SUM_W'(cross_a) + SUM_W'(cross_b) + SUM_W'(cross_c) + SUM_W'(cross_d);
      end
   end

   // Stage 4: raw advection products.
   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         c4_ff  <= c3_ff;
         lx4_ff <= lx3_ff;
         ly4_ff <= ly3_ff;
         pa4_ff <= c3_ff * sd3_ff;
         pb4_ff <= cs3_ff * cd3_ff;
      end
   end

   // Stage 5: back to velocity scale; the cross sum carries a quarter.
   always_ff @(posedge clock) begin
      if (stage_en.s5) begin
         c5_ff  <= c4_ff;
         lx5_ff <= lx4_ff;
         ly5_ff <= ly4_ff;
         a5_ff  <= ADV_W'(round_shift(RND_W'(pa4_ff), FRAC_BITS));
         b5_ff  <= ADV_W'(round_shift(RND_W'(pb4_ff), FRAC_BITS + 2));
      end
   end

   always_comb begin
      op5[0]  = OP_W'(lx5_ff);
      op5[1]  = OP_W'(ly5_ff);
      op5[2]  = a5_ff;
      op5[3]  = b5_ff;
      gain[0] = gain_lap_x;
      gain[1] = gain_lap_y;
      gain[2] = gain_self;
      gain[3] = gain_cross;
   end

   // Stage 6: each term times the low and the high half of its gain.
   always_ff @(posedge clock) begin
      if (stage_en.s6) begin
         c6_ff <= c5_ff;
         for (int k = 0; k < 4; k++) begin
            plo6_ff[k] <= PART_W'(op5[k] * $signed({1'b0, gain[k][GAIN_LO_W-1:0]}));
            phi6_ff[k] <= PART_W'(op5[k] * $signed({1'b0, gain[k][GAIN_W-1:GAIN_LO_W]}));
         end
      end
   end

   // Stage 7: join the halves and drop the gain fraction with rounding.
   always_ff @(posedge clock) begin
      if (stage_en.s7) begin
         c7_ff <= c6_ff;
         for (int k = 0; k < 4; k++) begin
            t7_ff[k] <= TERM_W'(round_shift((RND_W'(phi6_ff[k]) <<< GAIN_LO_W)
                                            + RND_W'(plo6_ff[k]), GAIN_W));
         end
      end
   end

   assign sum7 = RES_W'(c7_ff) + RES_W'(t7_ff[0]) + RES_W'(t7_ff[1])
                 - RES_W'(t7_ff[2]) - RES_W'(t7_ff[3]);

   // Stage 8: sum the terms and clip to the velocity range.
   always_ff @(posedge clock) begin
      if (stage_en.s8) begin
         centre8_ff <= c7_ff;
         if (sum7 > RES_MAX) begin
            pred_ff <= VW'(RES_MAX);
            sat_ff  <= 1'b1;
         end else if (sum7 < RES_MIN) begin
            pred_ff <= VW'(RES_MIN);
            sat_ff  <= 1'b1;
         end else begin
            pred_ff <= VW'(sum7);
            sat_ff  <= 1'b0;
         end
      end
   end

   assign pred       = pred_ff;
   assign centre_out = centre8_ff;
   assign sat        = sat_ff;

endmodule
